// File: design/twcw_pkg.sv
// Shared types, codes and constants of the text window console writer.
`timescale 1ns / 1ps
`default_nettype none
package twcw_pkg;

  // Default sizes of the text buffer
  localparam int MAX_WINDOWS_DEF = 4;
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 32;

  // Command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register indexes of the configuration port
  localparam int         PADDR_W  = 4;
  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_WINS = 2'd2;
  localparam logic [1:0] REG_VIS  = 2'd3;

  // Register reset values
  localparam logic [7:0] COLS_RST = 8'd78;
  localparam logic [5:0] ROWS_RST = 6'd22;
  localparam logic [2:0] WINS_RST = 3'd0;
  localparam logic [3:0] VIS_RST  = 4'd0;

  // Character codes
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] window;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

  typedef struct packed {
    logic       ignored;
    logic       scrolled;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
  } res_t;

  typedef struct packed {
    logic [7:0] text_columns;
    logic [5:0] text_rows;
    logic [2:0] window_count;
    logic [3:0] visible_mask;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/twcw_cfg.sv
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps
`default_nettype none
module twcw_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel_i,
  input  wire logic                        penable_i,
  input  wire logic                        pwrite_i,
  input  wire logic [twcw_pkg::PADDR_W-1:0] paddr_i,
  input  wire logic [31:0]                 pwdata_i,
  output logic      [31:0]                 prdata_o,
  output logic                             pready_o,
  output twcw_pkg::cfg_t                   cfg_o
);

  twcw_pkg::cfg_t cfg_q;
  logic [1:0]     reg_idx;

  assign reg_idx = paddr_i[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_columns <= twcw_pkg::COLS_RST;
      cfg_q.text_rows    <= twcw_pkg::ROWS_RST;
      cfg_q.window_count <= twcw_pkg::WINS_RST;
      cfg_q.visible_mask <= twcw_pkg::VIS_RST;
    end else if (psel_i && penable_i && pwrite_i) begin
      case (reg_idx)
        twcw_pkg::REG_COLS: cfg_q.text_columns <= pwdata_i[7:0];
        twcw_pkg::REG_ROWS: cfg_q.text_rows    <= pwdata_i[5:0];
        twcw_pkg::REG_WINS: cfg_q.window_count <= pwdata_i[2:0];
        twcw_pkg::REG_VIS:  cfg_q.visible_mask <= pwdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      twcw_pkg::REG_COLS: prdata_o = 32'(cfg_q.text_columns);
      twcw_pkg::REG_ROWS: prdata_o = 32'(cfg_q.text_rows);
      twcw_pkg::REG_WINS: prdata_o = 32'(cfg_q.window_count);
      twcw_pkg::REG_VIS:  prdata_o = 32'(cfg_q.visible_mask);
      default:            prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

endmodule
`default_nettype wire

// File: design/twcw_engine.sv
// Command sequencer with the shared cell address unit and the text buffer.
`timescale 1ns / 1ps
`default_nettype none
module twcw_engine #(
  parameter int MAX_WINDOWS = twcw_pkg::MAX_WINDOWS_DEF,
  parameter int MAX_COLUMNS = twcw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = twcw_pkg::MAX_ROWS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire twcw_pkg::cfg_t cfg_i,
  input  wire logic           start_i,
  input  wire twcw_pkg::cmd_t item_i,
  output logic                busy_o,
  output logic                done_o,
  output twcw_pkg::res_t      res_o
);

  localparam int WIN_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CIX_W  = $clog2(MAX_COLUMNS);
  localparam int RIX_W  = $clog2(MAX_ROWS);
  localparam int COLN_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROWN_W = $clog2(MAX_ROWS + 1);
  localparam int DEPTH  = MAX_WINDOWS * MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [WIN_W-1:0] WLAST = WIN_W'(MAX_WINDOWS - 1);
  localparam logic [RIX_W-1:0] RLAST = RIX_W'(MAX_ROWS - 1);
  localparam logic [CIX_W-1:0] CLAST = CIX_W'(MAX_COLUMNS - 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_EXEC, S_SCR_RD, S_SCR_WR, S_SCR_BLK, S_CLR, S_FIN
  } state_e;

  state_e          state_q;
  twcw_pkg::cmd_t  item_q;
  logic [WIN_W-1:0] w_q;
  logic [RIX_W-1:0] r_q;
  logic [CIX_W-1:0] c_q;
  logic [CIX_W-1:0] cur_c_q [MAX_WINDOWS];
  logic [RIX_W-1:0] cur_r_q [MAX_WINDOWS];
  logic            ignored_q;
  logic            scrolled_q;
  logic            rd_ok_q;
  logic [7:0]      rdata_q;
  logic [7:0]      mem [DEPTH];

  logic [COLN_W-1:0] cols;
  logic [ROWN_W-1:0] rows;
  logic              win_ok, created, shown, in_range, ign;
  logic [CIX_W-1:0]  cur_c;
  logic [RIX_W-1:0]  cur_r;
  logic [COLN_W-1:0] cx, nx, wr_col;
  logic [ROWN_W-1:0] cy, ny, ny_fin;
  logic              put_wr, scroll;
  logic [7:0]        put_char;
  logic              col_last, row_next_last;
  logic [RIX_W-1:0]  a_row;
  logic [CIX_W-1:0]  a_col;
  logic [ADDR_W-1:0] addr;
  logic              we;
  logic [7:0]        wdata;

  // Shared cell address unit: window, row and column to a flat buffer address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [WIN_W-1:0] w,
                                                  input logic [RIX_W-1:0] r,
                                                  input logic [CIX_W-1:0] c);
    logic [ADDR_W-1:0] row_idx;
    row_idx = ADDR_W'(w) * ADDR_W'(MAX_ROWS) + ADDR_W'(r);
    return row_idx * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
  endfunction

  // Saturate the configured text size; a size of zero is taken as one
  always_comb begin
    if (cfg_i.text_columns == 8'd0) begin
      cols = COLN_W'(1);
    end else if (32'(cfg_i.text_columns) > MAX_COLUMNS) begin
      cols = COLN_W'(MAX_COLUMNS);
    end else begin
      cols = COLN_W'(cfg_i.text_columns);
    end
    if (cfg_i.text_rows == 6'd0) begin
      rows = ROWN_W'(1);
    end else if (32'(cfg_i.text_rows) > MAX_ROWS) begin
      rows = ROWN_W'(MAX_ROWS);
    end else begin
      rows = ROWN_W'(cfg_i.text_rows);
    end
  end

  assign win_ok   = 32'(item_q.window) < MAX_WINDOWS;
  assign created  = win_ok && (3'(item_q.window) < cfg_i.window_count);
  assign shown    = created && cfg_i.visible_mask[item_q.window];
  assign in_range = (32'(item_q.read_row) < 32'(rows)) &&
                    (32'(item_q.read_col) < 32'(cols));
  assign cur_c    = cur_c_q[w_q];
  assign cur_r    = cur_r_q[w_q];

  always_comb begin
    case (item_q.command)
      twcw_pkg::CMD_PUT:   ign = !shown;
      twcw_pkg::CMD_CLEAR: ign = !created;
      twcw_pkg::CMD_READ:  ign = !created;
      default:             ign = 1'b1;
    endcase
  end

  // Cursor motion of one put character
  always_comb begin
    cx = (COLN_W'(cur_c) >= cols) ? cols - COLN_W'(1) : COLN_W'(cur_c);
    cy = (ROWN_W'(cur_r) >= rows) ? rows - ROWN_W'(1) : ROWN_W'(cur_r);
    nx       = cx;
    ny       = cy;
    put_wr   = 1'b0;
    wr_col   = cx;
    put_char = item_q.char_code;
    if (item_q.char_code == twcw_pkg::CH_NL) begin
      nx = '0;
      ny = cy + ROWN_W'(1);
    end else if (item_q.char_code == twcw_pkg::CH_CR) begin
      nx = '0;
    end else if (item_q.char_code == twcw_pkg::CH_BS) begin
      if (cx != '0) begin
        nx       = cx - COLN_W'(1);
        wr_col   = cx - COLN_W'(1);
        put_wr   = 1'b1;
        put_char = twcw_pkg::CH_BLANK;
      end
    end else if (item_q.char_code >= twcw_pkg::CH_BLANK &&
                 item_q.char_code <= twcw_pkg::CH_PRINT_HI) begin
      put_wr = 1'b1;
      if (cx + COLN_W'(1) >= cols) begin
        nx = '0;
        ny = cy + ROWN_W'(1);
      end else begin
        nx = cx + COLN_W'(1);
      end
    end
    scroll = ny >= rows;
    ny_fin = scroll ? rows - ROWN_W'(1) : ny;
  end

  assign col_last      = COLN_W'(c_q) == cols - COLN_W'(1);
  assign row_next_last = ROWN_W'(r_q) + ROWN_W'(1) == rows - ROWN_W'(1);

  // Operand selection for the address unit and the buffer write port
  always_comb begin
    a_row = r_q;
    a_col = c_q;
    we    = 1'b0;
    wdata = twcw_pkg::CH_BLANK;
    case (state_q)
      S_INIT, S_CLR, S_SCR_BLK: we = 1'b1;
      S_SCR_RD: a_row = r_q + RIX_W'(1);
      S_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      S_EXEC: begin
        if (item_q.command == twcw_pkg::CMD_READ) begin
          a_row = RIX_W'(item_q.read_row);
          a_col = CIX_W'(item_q.read_col);
        end else begin
          a_row = RIX_W'(cy);
          a_col = CIX_W'(wr_col);
        end
        we    = (item_q.command == twcw_pkg::CMD_PUT) && shown && put_wr;
        wdata = put_char;
      end
      default: ;
    endcase
  end

  assign addr = cell_addr(w_q, a_row, a_col);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      w_q        <= '0;
      r_q        <= '0;
      c_q        <= '0;
      ignored_q  <= 1'b0;
      scrolled_q <= 1'b0;
      rd_ok_q    <= 1'b0;
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        cur_c_q[i] <= '0;
        cur_r_q[i] <= '0;
      end
    end else begin
      case (state_q)
        // Blank the whole buffer once after reset
        S_INIT: begin
          if (c_q == CLAST) begin
            c_q <= '0;
            if (r_q == RLAST) begin
              r_q <= '0;
              if (w_q == WLAST) begin
                state_q <= S_IDLE;
              end else begin
                w_q <= w_q + WIN_W'(1);
              end
            end else begin
              r_q <= r_q + RIX_W'(1);
            end
          end else begin
            c_q <= c_q + CIX_W'(1);
          end
        end
        S_IDLE, S_FIN: begin
          if (start_i) begin
            w_q     <= WIN_W'(item_i.window);
            state_q <= S_EXEC;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EXEC: begin
          ignored_q  <= ign;
          scrolled_q <= 1'b0;
          rd_ok_q    <= 1'b0;
          r_q        <= '0;
          c_q        <= '0;
          state_q    <= S_FIN;
          case (item_q.command)
            twcw_pkg::CMD_PUT: begin
              if (shown) begin
                cur_c_q[w_q] <= CIX_W'(nx);
                cur_r_q[w_q] <= RIX_W'(ny_fin);
                scrolled_q   <= scroll;
                if (scroll) begin
                  state_q <= (rows > ROWN_W'(1)) ? S_SCR_RD : S_SCR_BLK;
                end
              end
            end
            twcw_pkg::CMD_CLEAR: begin
              if (created) begin
                cur_c_q[w_q] <= '0;
                cur_r_q[w_q] <= '0;
                state_q      <= S_CLR;
              end
            end
            twcw_pkg::CMD_READ: rd_ok_q <= created && in_range;
            default: ;
          endcase
        end
        S_SCR_RD: state_q <= S_SCR_WR;
        // Move row r+1 into row r, one cell per read and write pair
        S_SCR_WR: begin
          state_q <= S_SCR_RD;
          if (col_last) begin
            c_q <= '0;
            r_q <= r_q + RIX_W'(1);
            if (row_next_last) begin
              state_q <= S_SCR_BLK;
            end
          end else begin
            c_q <= c_q + CIX_W'(1);
          end
        end
        S_SCR_BLK: begin
          if (col_last) begin
            state_q <= S_FIN;
          end else begin
            c_q <= c_q + CIX_W'(1);
          end
        end
        // Blank every cell of the window, whatever the current text size
        S_CLR: begin
          if (c_q == CLAST) begin
            c_q <= '0;
            if (r_q == RLAST) begin
              state_q <= S_FIN;
            end else begin
              r_q <= r_q + RIX_W'(1);
            end
          end else begin
            c_q <= c_q + CIX_W'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = !(state_q == S_IDLE || state_q == S_FIN);
  assign done_o = state_q == S_FIN;

  always_comb begin
    res_o.ignored    = ignored_q;
    res_o.scrolled   = scrolled_q;
    res_o.cursor_col = win_ok ? 7'(cur_c) : 7'd0;
    res_o.cursor_row = win_ok ? 5'(cur_r) : 5'd0;
    res_o.cell_char  = rd_ok_q ? rdata_q : 8'd0;
  end

endmodule
`default_nettype wire

// File: design/text_window_console_writer.sv
// Top level of the text window console writer.
`timescale 1ns / 1ps
`default_nettype none
// Text console writer for up to MAX_WINDOWS windows sharing one text buffer
// memory with a single port. A command is taken when start is high and busy
// is low; its result appears on res_o for exactly one cycle with done_o high
// and cannot be stalled, so the receiver must take it then. A new command may
// be started in the same cycle that a result is shown. A put character
// without scroll, a read and an ignored command are carried out in the execute
// state and then show their result. A scroll adds one read and one write per
// moved cell and one write per blanked cell. A clear adds one write per cell
// of the window. After reset the block blanks every cell of the buffer with
// busy high; configuration writes are taken meanwhile. Write configuration
// only while no command is in progress.
module text_window_console_writer #(
  parameter int MAX_WINDOWS = twcw_pkg::MAX_WINDOWS_DEF,
  parameter int MAX_COLUMNS = twcw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = twcw_pkg::MAX_ROWS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [twcw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  input  wire logic                         start,
  output logic                              busy,
  input  wire twcw_pkg::cmd_t               cmd_i,
  output logic                              done_o,
  output twcw_pkg::res_t                    res_o
);

  twcw_pkg::cfg_t cfg;

  twcw_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  twcw_engine #(
    .MAX_WINDOWS (MAX_WINDOWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .start_i (start),
    .item_i  (cmd_i),
    .busy_o  (busy),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule
`default_nettype wire

// File: sim/text_window_console_writer_test.sv
// Self-checking testbench for the text window console writer.
`timescale 1ns / 1ps
module text_window_console_writer_test;
  import twcw_pkg::*;

  localparam int          CLK_PERIOD = 20;
  localparam longint      TIMEOUT_NS = 64'd40_000_000;
  localparam int          NUM_WIN    = MAX_WINDOWS_DEF;
  localparam int          NUM_COL    = MAX_COLUMNS_DEF;
  localparam int          NUM_ROW    = MAX_ROWS_DEF;
  localparam logic [1:0]  CMD_NONE   = 2'd3;
  localparam int unsigned DRAIN_CYC  = 20;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                start   = 1'b0;
  logic                busy;
  cmd_t                cmd_i   = '0;
  logic                done_o;
  res_t                res_o;

  // Model of the console: buffer, cursors and registers
  logic [7:0]  screen_mem [NUM_WIN][NUM_ROW][NUM_COL];
  int          col_pos [NUM_WIN];
  int          row_pos [NUM_WIN];
  cfg_t        cfg_model;

  cmd_t        pending_cmds[$];
  res_t        expected_results[$];
  res_t        want_res;
  int unsigned gap_pct = 31;
  int          fail_count = 0;

  text_window_console_writer u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int cols_in_use();
    int n;
    n = cfg_model.text_columns;
    if (n < 1) n = 1;
    if (n > NUM_COL) n = NUM_COL;
    return n;
  endfunction

  function automatic int rows_in_use();
    int n;
    n = cfg_model.text_rows;
    if (n < 1) n = 1;
    if (n > NUM_ROW) n = NUM_ROW;
    return n;
  endfunction

  function automatic logic put_char(int w, logic [7:0] code);
    int   ncol, nrow, cx, cy, r, k;
    logic rolled;
    ncol   = cols_in_use();
    nrow   = rows_in_use();
    cx     = col_pos[w];
    cy     = row_pos[w];
    rolled = 1'b0;
    // clamp a cursor left outside a shrunken text area
    if (cx >= ncol) cx = ncol - 1;
    if (cy >= nrow) cy = nrow - 1;
    if (code == CH_NL) begin
      cx = 0;
      cy++;
    end else if (code == CH_CR) begin
      cx = 0;
    end else if (code == CH_BS) begin
      if (cx > 0) begin
        cx--;
        screen_mem[w][cy][cx] = CH_BLANK;
      end
    end else if (code >= CH_BLANK && code <= CH_PRINT_HI) begin
      screen_mem[w][cy][cx] = code;
      cx++;
      if (cx >= ncol) begin
        cx = 0;
        cy++;
      end
    end
    if (cy >= nrow) begin
      for (r = 0; r + 1 < nrow; r++)
        for (k = 0; k < ncol; k++) screen_mem[w][r][k] = screen_mem[w][r + 1][k];
      for (k = 0; k < ncol; k++) screen_mem[w][nrow - 1][k] = CH_BLANK;
      cy     = nrow - 1;
      rolled = 1'b1;
    end
    col_pos[w] = cx;
    row_pos[w] = cy;
    return rolled;
  endfunction

  function automatic res_t console_step(cmd_t c);
    res_t r;
    int   w, row, col;
    logic created, shown;
    r       = '0;
    w       = c.window;
    created = w < cfg_model.window_count;
    shown   = created && cfg_model.visible_mask[w];
    case (c.command)
      CMD_PUT: begin
        if (shown) r.scrolled = put_char(w, c.char_code);
        else r.ignored = 1'b1;
      end
      CMD_CLEAR: begin
        if (created) begin
          for (row = 0; row < NUM_ROW; row++)
            for (col = 0; col < NUM_COL; col++) screen_mem[w][row][col] = CH_BLANK;
          col_pos[w] = 0;
          row_pos[w] = 0;
        end else begin
          r.ignored = 1'b1;
        end
      end
      CMD_READ: begin
        if (!created) r.ignored = 1'b1;
        else if (c.read_row < rows_in_use() && c.read_col < cols_in_use())
          r.cell_char = screen_mem[w][c.read_row][c.read_col];
      end
      default: r.ignored = 1'b1;
    endcase
    r.cursor_col = 7'(col_pos[w]);
    r.cursor_row = 5'(row_pos[w]);
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    logic [31:0] bits;
    int unsigned pick;
    bits = $urandom;
    c    = bits[$bits(cmd_t)-1:0];
    pick = $urandom_range(99);
    if (pick < 72) c.command = CMD_PUT;
    else if (pick < 74) c.command = CMD_CLEAR;
    else if (pick < 96) c.command = CMD_READ;
    else c.command = CMD_NONE;
    // mostly text with line controls; the rest keeps the full random byte
    pick = $urandom_range(99);
    if (pick < 60) c.char_code = 8'($urandom_range(CH_PRINT_HI, CH_BLANK));
    else if (pick < 72) c.char_code = CH_NL;
    else if (pick < 77) c.char_code = CH_CR;
    else if (pick < 85) c.char_code = CH_BS;
    if ($urandom_range(4) != 0) begin
      c.read_row = 5'($urandom_range(rows_in_use() - 1));
      c.read_col = 7'($urandom_range(cols_in_use() - 1));
    end
    return c;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [1:0] w,
                           input logic [7:0] code, input logic [4:0] row,
                           input logic [6:0] col);
    cmd_t c;
    c.command   = op;
    c.window    = w;
    c.char_code = code;
    c.read_row  = row;
    c.read_col  = col;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COLS: cfg_model.text_columns = value[7:0];
      REG_ROWS: cfg_model.text_rows    = value[5:0];
      REG_WINS: cfg_model.window_count = value[2:0];
      REG_VIS:  cfg_model.visible_mask = value[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] cols, input logic [5:0] rows,
                           input logic [2:0] wins, input logic [3:0] vis);
    wait_idle();
    write_reg(REG_COLS, {24'd0, cols});
    write_reg(REG_ROWS, {26'd0, rows});
    write_reg(REG_WINS, {29'd0, wins});
    write_reg(REG_VIS, {28'd0, vis});
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [5:0] rows,
                           input logic [2:0] wins, input logic [3:0] vis,
                           input int n, input int unsigned idle);
    int i;
    configure(cols, rows, wins, vis);
    gap_pct = idle;
    for (i = 0; i < n / 2; i++) pending_cmds.push_back(random_cmd());
    // hold the sender off until everything outstanding has come back
    wait_idle();
    for (i = n / 2; i < n; i++) pending_cmds.push_back(random_cmd());
  endtask

  // Driver: present the next command and predict each accepted transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      cmd_i <= '0;
    end else begin
      if (start && !busy) expected_results.push_back(console_step(cmd_i));
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          cmd_i <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: every done strobe is a transfer that must match the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no command outstanding: %h", res_o);
        fail_count++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("ignored", want_res.ignored, res_o.ignored);
        check_field("scrolled", want_res.scrolled, res_o.scrolled);
        check_field("cursor_col", want_res.cursor_col, res_o.cursor_col);
        check_field("cursor_row", want_res.cursor_row, res_o.cursor_row);
        check_field("cell_char", want_res.cell_char, res_o.cell_char);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int w, r, k;
    for (w = 0; w < NUM_WIN; w++) begin
      col_pos[w] = 0;
      row_pos[w] = 0;
      for (r = 0; r < NUM_ROW; r++)
        for (k = 0; k < NUM_COL; k++) screen_mem[w][r][k] = CH_BLANK;
    end
    cfg_model = '{COLS_RST, ROWS_RST, WINS_RST, VIS_RST};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Window 0 and 1 shown, window 2 hidden, window 3 not created
    configure(8'd8, 6'd2, 3'd3, 4'b1011);
    queue_cmd(CMD_PUT, 2'd0, 8'h41, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, CH_PRINT_HI, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, 8'h1F, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, 8'hFF, 5'd31, 7'd127);
    queue_cmd(CMD_PUT, 2'd0, CH_BS, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, CH_CR, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, CH_BS, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, CH_NL, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd0, CH_NL, 5'd0, 7'd0);
    // fill one whole row to force a wrap
    for (k = 0; k < 8; k++) queue_cmd(CMD_PUT, 2'd1, 8'(8'h61 + k), 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd2, 8'h78, 5'd0, 7'd0);
    queue_cmd(CMD_PUT, 2'd3, 8'h78, 5'd0, 7'd0);
    queue_cmd(CMD_READ, 2'd1, 8'h00, 5'd0, 7'd0);
    queue_cmd(CMD_READ, 2'd2, 8'h00, 5'd0, 7'd0);
    queue_cmd(CMD_READ, 2'd3, 8'h00, 5'd0, 7'd0);
    queue_cmd(CMD_READ, 2'd0, 8'h00, 5'd31, 7'd127);
    queue_cmd(CMD_CLEAR, 2'd2, 8'h00, 5'd0, 7'd0);
    queue_cmd(CMD_CLEAR, 2'd3, 8'h00, 5'd0, 7'd0);
    queue_cmd(CMD_NONE, 2'd1, 8'h00, 5'd0, 7'd0);

    run_phase(8'd8, 6'd2, 3'd4, 4'hF, 90, 31);
    run_phase(8'd16, 6'd4, 3'd4, 4'b0111, 90, 31);
    run_phase(8'd0, 6'd0, 3'd4, 4'hF, 40, 31);
    run_phase(8'd12, 6'd3, 3'd3, 4'b0101, 90, 63);
    run_phase(8'd10, 6'd2, 3'd7, 4'hF, 80, 63);
    run_phase(8'd8, 6'd32, 3'd4, 4'hF, 80, 63);
    run_phase(8'd255, 6'd63, 3'd4, 4'hF, 30, 0);
    run_phase(8'd128, 6'd2, 3'd4, 4'b1110, 60, 0);
    run_phase(8'd9, 6'd5, 3'd1, 4'b0001, 60, 0);
    run_phase(COLS_RST, ROWS_RST, WINS_RST, VIS_RST, 30, 0);
    run_phase(8'd8, 6'd2, 3'd4, 4'hF, 50, 0);

    wait_idle();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
